[hw/rtl/wzf_pkg.sv]
// wzf_pkg: types and constants shared by the window z-order and focus table
// covers slot table entries, stack memory ports, action, status and register codes
// no dependencies
package wzf_pkg;

  localparam int MAX_WINDOWS = 16;
  localparam int SLOT_W      = 4;
  localparam int HANDLE_W    = 5;
  localparam int CFG_W       = 12;
  localparam logic [15:0] STYLE_MASK = 16'h0178;

  typedef enum logic [3:0] {
    ACT_CREATE   = 4'd0,
    ACT_DESTROY  = 4'd1,
    ACT_SHOW     = 4'd2,
    ACT_HIDE     = 4'd3,
    ACT_MINIMIZE = 4'd4,
    ACT_MAXIMIZE = 4'd5,
    ACT_RESTORE  = 4'd6,
    ACT_MOVE     = 4'd7,
    ACT_RESIZE   = 4'd8,
    ACT_SET_RECT = 4'd9,
    ACT_FOCUS    = 4'd10,
    ACT_CYCLE    = 4'd11,
    ACT_HIT_TEST = 4'd12,
    ACT_READ     = 4'd13
  } act_e;

  localparam logic [1:0] STAT_OK         = 2'd0;
  localparam logic [1:0] STAT_BAD_HANDLE = 2'd1;
  localparam logic [1:0] STAT_FULL       = 2'd2;
  localparam logic [1:0] STAT_MODAL      = 2'd3;

  localparam logic [1:0] SHOW_NORMAL = 2'd0;
  localparam logic [1:0] SHOW_MIN    = 2'd1;
  localparam logic [1:0] SHOW_MAX    = 2'd2;

  localparam logic [1:0] CFG_SCREEN_W = 2'd0;
  localparam logic [1:0] CFG_WORK_H   = 2'd1;
  localparam logic [1:0] CFG_MODAL    = 2'd2;

  typedef struct packed {
    logic [3:0]         action;
    logic [4:0]         handle;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] size_w;
    logic signed [15:0] size_h;
    logic [15:0]        style_bits;
  } item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [4:0]         result_handle;
    logic [4:0]         focus_handle;
    logic [4:0]         window_count;
    logic signed [15:0] frame_x;
    logic signed [15:0] frame_y;
    logic signed [15:0] frame_w;
    logic signed [15:0] frame_h;
    logic [3:0]         mark_bits;
    logic [1:0]         show_state;
    logic [3:0]         z_position;
  } result_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] w;
    logic signed [15:0] h;
  } frame_t;

  typedef struct packed {
    logic [1:0] show;
    logic [8:0] style;
    frame_t     frame;
    frame_t     restore;
  } slot_t;

  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] addr;
    slot_t             data;
  } slot_wr_t;

  typedef struct packed {
    logic                we;
    logic [SLOT_W-1:0]   addr;
    logic [HANDLE_W-1:0] data;
  } zs_wr_t;

endpackage

[hw/rtl/wzf_slot_mem.sv]
// wzf_slot_mem: per-slot table of show state, style, frame and restore frame
// one write port, one read port with registered data; uses wzf_pkg
module wzf_slot_mem
  import wzf_pkg::*;
(
  input  logic              clk_i,
  input  slot_wr_t          wr_i,
  input  logic [SLOT_W-1:0] raddr_i,
  output slot_t             rdata_o
);

  slot_t mem [MAX_WINDOWS];
  slot_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/wzf_zstack_mem.sv]
// wzf_zstack_mem: bottom-to-top z-order stack of window handles
// one write port, one read port with registered data; uses wzf_pkg
module wzf_zstack_mem
  import wzf_pkg::*;
(
  input  logic                clk_i,
  input  zs_wr_t              wr_i,
  input  logic [SLOT_W-1:0]   raddr_i,
  output logic [HANDLE_W-1:0] rdata_o
);

  logic [HANDLE_W-1:0] mem [MAX_WINDOWS];
  logic [HANDLE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/window_zorder_focus_table.sv]
// window_zorder_focus_table: window slot table, z-order stack, focus and hit test
// create, show, hide and items that move nothing finish straight from dispatch; slot edits
// read and then write the slot entry; destroy, focus, read, hit test and focus cycling walk
// the z-order stack one entry at a time
// throughput: one item at a time, the next is taken at the edge that ends the result strobe
// receiver cannot stall; reset: asynchronous active low, empties the table, loads 640 x 460
module window_zorder_focus_table
  import wzf_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  item_t            item_i,
  output logic             done_o,
  output result_t          result_o,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i
);

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DISP,
    ST_FIND_RD,
    ST_FIND_CHK,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_SHIFT_END,
    ST_NEWTOP_RD,
    ST_NEWTOP_CHK,
    ST_SLOT_RD,
    ST_SLOT_WR,
    ST_HIT_ZRD,
    ST_HIT_SRD,
    ST_HIT_CHK,
    ST_CYC_RD,
    ST_CYC_CHK,
    ST_DONE
  } state_e;

  state_e state_q;

  // latched item
  logic [3:0]         act_q;
  logic [4:0]         h_q;
  logic signed [15:0] px_q, py_q, sw_q, sh_q;
  logic [8:0]         style_q;

  // table control state
  logic [4:0]             cnt_q;
  logic [4:0]             fh_q;
  logic [MAX_WINDOWS-1:0] alive_q;
  logic [MAX_WINDOWS-1:0] vis_q;
  logic [CFG_W-1:0]       scr_w_q, work_h_q;
  logic [4:0]             modal_q;

  // scan state
  logic [4:0] idx_q;
  logic [4:0] cand_q;

  // result fields
  logic [1:0] status_q;
  logic [4:0] res_q;
  frame_t     rd_frame_q;
  logic [3:0] rd_marks_q;
  logic [1:0] rd_show_q;
  logic [3:0] rd_zpos_q;
  logic       done_q;
  result_t    result_q;

  // memory ports
  zs_wr_t      z_wr;
  logic [3:0]  z_raddr;
  logic [4:0]  z_rdata;
  slot_wr_t    s_wr;
  logic [3:0]  s_raddr;
  slot_t       s_rdata;
  slot_t       slot_new;

  wzf_zstack_mem u_zstack (
    .clk_i   (clk_i),
    .wr_i    (z_wr),
    .raddr_i (z_raddr),
    .rdata_o (z_rdata)
  );

  wzf_slot_mem u_slots (
    .clk_i   (clk_i),
    .wr_i    (s_wr),
    .raddr_i (s_raddr),
    .rdata_o (s_rdata)
  );

  // handle to slot index, handles run from one
  logic [4:0] h_m1, idx_m1, idx_p1, idx_p2, cnt_m1, zr_m1, fh_m1;
  logic [3:0] h_slot, zr_slot, fh_slot;
  logic       h_ok;

  assign h_m1    = h_q - 5'd1;
  assign idx_m1  = idx_q - 5'd1;
  assign idx_p1  = idx_q + 5'd1;
  assign idx_p2  = idx_q + 5'd2;
  assign cnt_m1  = cnt_q - 5'd1;
  assign zr_m1   = z_rdata - 5'd1;
  assign fh_m1   = fh_q - 5'd1;
  assign h_slot  = h_m1[3:0];
  assign zr_slot = zr_m1[3:0];
  assign fh_slot = fh_m1[3:0];
  assign h_ok    = (h_q != 5'd0) && (h_q <= 5'(MAX_WINDOWS)) && alive_q[h_slot];

  // lowest free slot for create
  logic       free_found;
  logic [3:0] free_idx;

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = MAX_WINDOWS - 1; i >= 0; i--) begin
      if (!alive_q[i]) begin
        free_found = 1'b1;
        free_idx   = 4'(i);
      end
    end
  end

  // new frame of a created window
  frame_t in_frame;
  assign in_frame = '{x: px_q, y: py_q, w: sw_q, h: sh_q};

  // hit test: edges summed at 17 bits so they never wrap
  logic signed [16:0] hx, hy, fx, fy, fx_end, fy_end;
  logic               hit;

  always_comb begin
    hx     = {px_q[15], px_q};
    hy     = {py_q[15], py_q};
    fx     = {s_rdata.frame.x[15], s_rdata.frame.x};
    fy     = {s_rdata.frame.y[15], s_rdata.frame.y};
    fx_end = fx + {s_rdata.frame.w[15], s_rdata.frame.w};
    fy_end = fy + {s_rdata.frame.h[15], s_rdata.frame.h};
    hit    = (hx >= fx) && (hx < fx_end) && (hy >= fy) && (hy < fy_end);
  end

  // read-modify-write of one slot entry
  always_comb begin
    slot_new = s_rdata;
    if (act_q == ACT_MINIMIZE) begin
      slot_new.show = SHOW_MIN;
    end else if (act_q == ACT_MAXIMIZE) begin
      if (s_rdata.show == SHOW_NORMAL) begin
        slot_new.restore = s_rdata.frame;
      end
      slot_new.show    = SHOW_MAX;
      slot_new.frame.x = '0;
      slot_new.frame.y = '0;
      slot_new.frame.w = {4'd0, scr_w_q};
      slot_new.frame.h = {4'd0, work_h_q};
    end else if (act_q == ACT_RESTORE) begin
      if (s_rdata.show == SHOW_MAX) begin
        slot_new.frame = s_rdata.restore;
      end
      slot_new.show = SHOW_NORMAL;
    end else if (act_q == ACT_MOVE) begin
      slot_new.frame.x = px_q;
      slot_new.frame.y = py_q;
    end else if (act_q == ACT_RESIZE) begin
      slot_new.frame.w = sw_q;
      slot_new.frame.h = sh_q;
    end else if (act_q == ACT_SET_RECT) begin
      slot_new.frame = in_frame;
    end
  end

  // memory addressing per state
  always_comb begin
    z_raddr = idx_q[3:0];
    z_wr    = '0;
    s_raddr = h_slot;
    s_wr    = '0;
    unique case (state_q)
      ST_DISP: begin
        if (act_q == ACT_CREATE && free_found) begin
          s_wr.we           = 1'b1;
          s_wr.addr         = free_idx;
          s_wr.data.show    = SHOW_NORMAL;
          s_wr.data.style   = style_q;
          s_wr.data.frame   = in_frame;
          s_wr.data.restore = in_frame;
          z_wr.we           = 1'b1;
          z_wr.addr         = cnt_q[3:0];
          z_wr.data         = {1'b0, free_idx} + 5'd1;
        end
      end
      ST_SHIFT_RD: z_raddr = idx_p1[3:0];
      ST_SHIFT_WR: begin
        z_wr.we   = 1'b1;
        z_wr.addr = idx_q[3:0];
        z_wr.data = z_rdata;
      end
      ST_SHIFT_END: begin
        // raise: the window goes on top
        if (act_q != ACT_DESTROY) begin
          z_wr.we   = 1'b1;
          z_wr.addr = cnt_m1[3:0];
          z_wr.data = cand_q;
        end
      end
      ST_NEWTOP_RD: z_raddr = cnt_m1[3:0];
      ST_HIT_ZRD,
      ST_CYC_RD:    z_raddr = idx_m1[3:0];
      ST_HIT_SRD:   s_raddr = zr_slot;
      ST_SLOT_WR: begin
        if (act_q != ACT_READ) begin
          s_wr.we   = 1'b1;
          s_wr.addr = h_slot;
          s_wr.data = slot_new;
        end
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      fh_q     <= '0;
      alive_q  <= '0;
      vis_q    <= '0;
      scr_w_q  <= 12'd640;
      work_h_q <= 12'd460;
      modal_q  <= '0;
      done_q   <= 1'b0;
    end else begin
      done_q <= 1'b0;

      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_SCREEN_W: scr_w_q  <= cfg_data_i;
          CFG_WORK_H:   work_h_q <= cfg_data_i;
          CFG_MODAL:    modal_q  <= cfg_data_i[4:0];
          default: ;
        endcase
      end

      unique case (state_q)
        ST_IDLE: begin
          if (start) begin
            act_q      <= item_i.action;
            h_q        <= item_i.handle;
            px_q       <= item_i.pos_x;
            py_q       <= item_i.pos_y;
            sw_q       <= item_i.size_w;
            sh_q       <= item_i.size_h;
            style_q    <= item_i.style_bits[8:0] & STYLE_MASK[8:0];
            status_q   <= STAT_OK;
            res_q      <= '0;
            rd_frame_q <= '0;
            rd_marks_q <= '0;
            rd_show_q  <= '0;
            rd_zpos_q  <= '0;
            state_q    <= ST_DISP;
          end
        end

        ST_DISP: begin
          if (act_q == ACT_CREATE) begin
            if (free_found) begin
              alive_q[free_idx] <= 1'b1;
              vis_q[free_idx]   <= 1'b1;
              cnt_q             <= cnt_q + 5'd1;
              res_q             <= {1'b0, free_idx} + 5'd1;
            end else begin
              status_q <= STAT_FULL;
            end
            state_q <= ST_DONE;
          end else if (act_q == ACT_HIT_TEST) begin
            idx_q   <= cnt_q;
            state_q <= (cnt_q == 5'd0) ? ST_DONE : ST_HIT_ZRD;
          end else if (act_q == ACT_FOCUS) begin
            if (h_q == fh_q) begin
              state_q <= ST_DONE;
            end else if (modal_q != 5'd0 && h_q != modal_q) begin
              status_q <= STAT_MODAL;
              state_q  <= ST_DONE;
            end else if (h_q != 5'd0 && !h_ok) begin
              status_q <= STAT_BAD_HANDLE;
              state_q  <= ST_DONE;
            end else if (h_q == 5'd0) begin
              fh_q    <= '0;
              state_q <= ST_DONE;
            end else begin
              fh_q    <= h_q;
              cand_q  <= h_q;
              idx_q   <= '0;
              state_q <= ST_FIND_RD;
            end
          end else if (act_q == ACT_CYCLE) begin
            idx_q   <= cnt_q;
            state_q <= (cnt_q == 5'd0) ? ST_DONE : ST_CYC_RD;
          end else if (act_q > ACT_READ) begin
            state_q <= ST_DONE;
          end else if (!h_ok) begin
            status_q <= STAT_BAD_HANDLE;
            state_q  <= ST_DONE;
          end else if (act_q == ACT_DESTROY) begin
            alive_q[h_slot] <= 1'b0;
            vis_q[h_slot]   <= 1'b0;
            cand_q          <= h_q;
            idx_q           <= '0;
            state_q         <= ST_FIND_RD;
          end else if (act_q == ACT_SHOW) begin
            vis_q[h_slot] <= 1'b1;
            state_q       <= ST_DONE;
          end else if (act_q == ACT_HIDE) begin
            vis_q[h_slot] <= 1'b0;
            state_q       <= ST_DONE;
          end else begin
            if (act_q == ACT_MINIMIZE) begin
              vis_q[h_slot] <= 1'b0;
            end else if (act_q == ACT_RESTORE) begin
              vis_q[h_slot] <= 1'b1;
            end
            state_q <= ST_SLOT_RD;
          end
        end

        // search the stack bottom up for cand_q
        ST_FIND_RD: state_q <= ST_FIND_CHK;

        ST_FIND_CHK: begin
          if (z_rdata == cand_q) begin
            if (act_q == ACT_READ) begin
              rd_zpos_q <= idx_q[3:0];
              state_q   <= ST_DONE;
            end else begin
              state_q <= (idx_p1 < cnt_q) ? ST_SHIFT_RD : ST_SHIFT_END;
            end
          end else if (idx_p1 >= cnt_q) begin
            if (act_q == ACT_READ) begin
              rd_zpos_q <= cnt_q[3:0];
            end
            state_q <= ST_DONE;
          end else begin
            idx_q   <= idx_p1;
            state_q <= ST_FIND_RD;
          end
        end

        // close the gap: entry above moves down one place
        ST_SHIFT_RD: state_q <= ST_SHIFT_WR;

        ST_SHIFT_WR: begin
          idx_q   <= idx_p1;
          state_q <= (idx_p2 < cnt_q) ? ST_SHIFT_RD : ST_SHIFT_END;
        end

        ST_SHIFT_END: begin
          if (act_q == ACT_DESTROY) begin
            cnt_q <= cnt_m1;
            if (fh_q == h_q) begin
              fh_q    <= '0;
              state_q <= (cnt_m1 != 5'd0) ? ST_NEWTOP_RD : ST_DONE;
            end else begin
              state_q <= ST_DONE;
            end
          end else begin
            state_q <= ST_DONE;
          end
        end

        // focus passes to the new top window
        ST_NEWTOP_RD:  state_q <= ST_NEWTOP_CHK;

        ST_NEWTOP_CHK: begin
          fh_q    <= z_rdata;
          state_q <= ST_DONE;
        end

        ST_SLOT_RD: state_q <= ST_SLOT_WR;

        ST_SLOT_WR: begin
          if (act_q == ACT_READ) begin
            rd_frame_q <= s_rdata.frame;
            rd_show_q  <= s_rdata.show;
            // dirty is set on create and never cleared, so it follows alive
            rd_marks_q <= {1'b1, fh_q == h_q, vis_q[h_slot], 1'b1};
            cand_q     <= h_q;
            idx_q      <= '0;
            state_q    <= ST_FIND_RD;
          end else begin
            state_q <= ST_DONE;
          end
        end

        // hit test walks the stack top down
        ST_HIT_ZRD: state_q <= ST_HIT_SRD;

        ST_HIT_SRD: begin
          cand_q <= z_rdata;
          if (vis_q[zr_slot]) begin
            state_q <= ST_HIT_CHK;
          end else if (idx_q == 5'd1) begin
            state_q <= ST_DONE;
          end else begin
            idx_q   <= idx_m1;
            state_q <= ST_HIT_ZRD;
          end
        end

        ST_HIT_CHK: begin
          if (hit) begin
            res_q   <= cand_q;
            state_q <= ST_DONE;
          end else if (idx_q == 5'd1) begin
            state_q <= ST_DONE;
          end else begin
            idx_q   <= idx_m1;
            state_q <= ST_HIT_ZRD;
          end
        end

        // focus cycling: topmost visible window other than the focused one
        ST_CYC_RD: state_q <= ST_CYC_CHK;

        ST_CYC_CHK: begin
          if (z_rdata != fh_q && alive_q[zr_slot] && vis_q[zr_slot]) begin
            if (modal_q != 5'd0 && z_rdata != modal_q) begin
              status_q <= STAT_MODAL;
              state_q  <= ST_DONE;
            end else begin
              fh_q    <= z_rdata;
              cand_q  <= z_rdata;
              idx_q   <= '0;
              state_q <= ST_FIND_RD;
            end
          end else if (idx_q == 5'd1) begin
            state_q <= ST_DONE;
          end else begin
            idx_q   <= idx_m1;
            state_q <= ST_CYC_RD;
          end
        end

        ST_DONE: begin
          done_q   <= 1'b1;
          result_q <= '{status:        status_q,
                        result_handle: res_q,
                        focus_handle:  fh_q,
                        window_count:  cnt_q,
                        frame_x:       rd_frame_q.x,
                        frame_y:       rd_frame_q.y,
                        frame_w:       rd_frame_q.w,
                        frame_h:       rd_frame_q.h,
                        mark_bits:     rd_marks_q,
                        show_state:    rd_show_q,
                        z_position:    rd_zpos_q};
          state_q  <= ST_IDLE;
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign busy     = (state_q != ST_IDLE);
  assign done_o   = done_q;
  assign result_o = result_q;

  // the stack never holds more windows than there are slots
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 5'(MAX_WINDOWS))
    else $error("stack count beyond slot count");

  // a visible slot is always a live slot
  a_vis_alive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vis_q & ~alive_q) == '0)
    else $error("visible mark on a free slot");

  // between items the stack holds exactly the live windows
  a_idle_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (cnt_q == 5'($countones(alive_q))))
    else $error("stack count differs from live slots");

  // focus only ever rests on a live window
  a_focus_alive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && fh_q != 5'd0) |-> alive_q[fh_slot])
    else $error("focus on a free slot");

  // one result per item, strobe never stretched
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("result strobe held");

endmodule

[tb/window_zorder_focus_table_tb.sv]
// window_zorder_focus_table_tb: self-checking testbench for the window z-order and focus table
// drives actions through the start/busy port, predicts each result from a model of the slot table
// depends on wzf_pkg and window_zorder_focus_table
module window_zorder_focus_table_tb;
  import wzf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic             clk_i;
  logic             rst_ni;
  logic             start;
  logic             busy;
  item_t            item_i;
  logic             done_o;
  result_t          result_o;
  logic             cfg_we_i;
  logic [1:0]       cfg_idx_i;
  logic [CFG_W-1:0] cfg_data_i;

  window_zorder_focus_table u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .item_i(item_i),
    .done_o(done_o), .result_o(result_o), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  localparam logic [3:0] MK_ALIVE   = 4'd1;
  localparam logic [3:0] MK_VISIBLE = 4'd2;
  localparam logic [3:0] MK_FOCUSED = 4'd4;
  localparam logic [3:0] MK_DIRTY   = 4'd8;

  // predicted copy of the table
  logic [3:0]  mdl_marks [MAX_WINDOWS];
  logic [8:0]  mdl_style [MAX_WINDOWS];
  logic [1:0]  mdl_show  [MAX_WINDOWS];
  frame_t      mdl_frame [MAX_WINDOWS];
  frame_t      mdl_rest  [MAX_WINDOWS];
  logic [4:0]  mdl_stack [MAX_WINDOWS];
  int          mdl_count;
  logic [4:0]  mdl_focus;
  logic [11:0] mdl_screen_w;
  logic [11:0] mdl_work_h;
  logic [4:0]  mdl_modal;

  item_t   pending_items[$];
  result_t expected_results[$];
  int      mismatches;
  int      sender_idle_pct;
  bit      hold_off;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic bit is_alive(logic [4:0] h);
    return h >= 1 && h <= MAX_WINDOWS && mdl_marks[h-1][0];
  endfunction

  function automatic int stack_pos(logic [4:0] h);
    for (int i = 0; i < mdl_count; i++) if (mdl_stack[i] == h) return i;
    return mdl_count;
  endfunction

  function automatic void pull_from_stack(int p);
    for (int j = p; j + 1 < mdl_count; j++) mdl_stack[j] = mdl_stack[j+1];
  endfunction

  function automatic logic [1:0] attempt_focus(logic [4:0] h);
    int p;
    if (h == mdl_focus) return STAT_OK;
    if (mdl_modal != 0 && h != mdl_modal) return STAT_MODAL;
    if (h != 0 && !is_alive(h)) return STAT_BAD_HANDLE;
    // old holder loses focus and is marked for redraw
    if (is_alive(mdl_focus)) begin
      mdl_marks[mdl_focus-1] = (mdl_marks[mdl_focus-1] & ~MK_FOCUSED) | MK_DIRTY;
    end
    mdl_focus = h;
    if (h != 0) begin
      mdl_marks[h-1] |= MK_FOCUSED | MK_DIRTY;
      p = stack_pos(h);
      if (p < mdl_count) begin
        pull_from_stack(p);
        mdl_stack[mdl_count-1] = h;
      end
    end
    return STAT_OK;
  endfunction

  // works out the result of one action and updates the table copy
  function automatic result_t predict_window_action(item_t it);
    result_t r;
    int s, p;
    logic [4:0] w;
    logic signed [16:0] px, py, fx, fy;
    r = '0;
    s = is_alive(it.handle) ? it.handle - 1 : 0;
    case (it.action)
      ACT_CREATE: begin
        r.status = STAT_FULL;
        for (int i = 0; i < MAX_WINDOWS; i++) begin
          if (!mdl_marks[i][0]) begin
            mdl_marks[i] = MK_ALIVE | MK_VISIBLE | MK_DIRTY;
            mdl_style[i] = 9'(it.style_bits & STYLE_MASK);
            mdl_show[i]  = SHOW_NORMAL;
            mdl_frame[i] = '{it.pos_x, it.pos_y, it.size_w, it.size_h};
            mdl_rest[i]  = mdl_frame[i];
            if (mdl_count < MAX_WINDOWS) begin
              mdl_stack[mdl_count] = 5'(i + 1);
              mdl_count++;
            end
            r.result_handle = 5'(i + 1);
            r.status = STAT_OK;
            break;
          end
        end
      end
      ACT_HIT_TEST: begin
        px = it.pos_x;
        py = it.pos_y;
        for (int i = mdl_count; i > 0; i--) begin
          w = mdl_stack[i-1];
          if (w < 1 || w > MAX_WINDOWS) continue;
          if (!mdl_marks[w-1][1]) continue;
          fx = mdl_frame[w-1].x;
          fy = mdl_frame[w-1].y;
          // 17-bit sums, no wrap
          if (px >= fx && px < fx + 17'(mdl_frame[w-1].w) &&
              py >= fy && py < fy + 17'(mdl_frame[w-1].h)) begin
            r.result_handle = w;
            break;
          end
        end
      end
      ACT_FOCUS: r.status = attempt_focus(it.handle);
      ACT_CYCLE: begin
        for (int i = mdl_count; i > 0; i--) begin
          w = mdl_stack[i-1];
          if (w != mdl_focus && is_alive(w) && mdl_marks[w-1][1]) begin
            r.status = attempt_focus(w);
            break;
          end
        end
      end
      default: begin
        if (it.action > ACT_READ) begin
          // unknown action, nothing changes
        end else if (!is_alive(it.handle)) begin
          r.status = STAT_BAD_HANDLE;
        end else begin
          case (it.action)
            ACT_DESTROY: begin
              p = stack_pos(it.handle);
              if (p < mdl_count) begin
                pull_from_stack(p);
                mdl_count--;
              end
              if (mdl_focus == it.handle) begin
                mdl_focus = 0;
                if (mdl_count > 0) begin
                  w = mdl_stack[mdl_count-1];
                  mdl_focus = w;
                  mdl_marks[w-1] |= MK_FOCUSED | MK_DIRTY;
                end
              end
              mdl_marks[s] = '0;
              mdl_style[s] = '0;
              mdl_show[s]  = SHOW_NORMAL;
              mdl_frame[s] = '0;
              mdl_rest[s]  = '0;
            end
            ACT_SHOW: mdl_marks[s] |= MK_VISIBLE | MK_DIRTY;
            ACT_HIDE: mdl_marks[s] &= ~MK_VISIBLE;
            ACT_MINIMIZE: begin
              mdl_show[s] = SHOW_MIN;
              mdl_marks[s] &= ~MK_VISIBLE;
            end
            ACT_MAXIMIZE: begin
              if (mdl_show[s] == SHOW_NORMAL) mdl_rest[s] = mdl_frame[s];
              mdl_show[s] = SHOW_MAX;
              mdl_frame[s] = '{16'sd0, 16'sd0, 16'({4'd0, mdl_screen_w}),
                               16'({4'd0, mdl_work_h})};
              mdl_marks[s] |= MK_DIRTY;
            end
            ACT_RESTORE: begin
              if (mdl_show[s] == SHOW_MAX) mdl_frame[s] = mdl_rest[s];
              mdl_show[s] = SHOW_NORMAL;
              mdl_marks[s] |= MK_VISIBLE | MK_DIRTY;
            end
            ACT_MOVE: begin
              mdl_frame[s].x = it.pos_x;
              mdl_frame[s].y = it.pos_y;
              mdl_marks[s] |= MK_DIRTY;
            end
            ACT_RESIZE: begin
              mdl_frame[s].w = it.size_w;
              mdl_frame[s].h = it.size_h;
              mdl_marks[s] |= MK_DIRTY;
            end
            ACT_SET_RECT: begin
              mdl_frame[s] = '{it.pos_x, it.pos_y, it.size_w, it.size_h};
              mdl_marks[s] |= MK_DIRTY;
            end
            default: begin
              r.frame_x    = mdl_frame[s].x;
              r.frame_y    = mdl_frame[s].y;
              r.frame_w    = mdl_frame[s].w;
              r.frame_h    = mdl_frame[s].h;
              r.mark_bits  = mdl_marks[s];
              r.show_state = mdl_show[s];
              r.z_position = 4'(stack_pos(it.handle));
            end
          endcase
        end
      end
    endcase
    r.focus_handle = mdl_focus;
    r.window_count = 5'(mdl_count);
    return r;
  endfunction

  // driver: one item in flight; once an item is taken the next is offered at once or start is lowered
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start  <= 1'b0;
      item_i <= '0;
    end else if (start && !busy) begin
      expected_results.push_back(predict_window_action(item_i));
      if (pending_items.size() > 0 && !hold_off &&
          $urandom_range(99) >= sender_idle_pct) begin
        item_i <= pending_items.pop_front();
      end else begin
        start <= 1'b0;
      end
    end else if (!start && pending_items.size() > 0 && !hold_off &&
                 $urandom_range(99) >= sender_idle_pct) begin
      start  <= 1'b1;
      item_i <= pending_items.pop_front();
    end
  end

  // monitor: every strobe must meet the oldest prediction
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && done_o) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", result_o);
      end else begin
        want = expected_results.pop_front();
        if (result_o !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p got %p", want, result_o);
        end
      end
    end
  end

  // random item, mostly aimed at handles in the slot range
  function automatic item_t random_item();
    item_t it;
    int pick;
    it.action = 4'($urandom_range(15));
    pick = $urandom_range(9);
    if (it.action == ACT_CREATE && pick < 3) it.action = ACT_DESTROY;
    if (pick == 0) it.handle = 5'($urandom_range(31));
    else it.handle = 5'($urandom_range(MAX_WINDOWS, 1));
    if ($urandom_range(3) == 0) begin
      it.pos_x  = 16'($urandom);
      it.pos_y  = 16'($urandom);
      it.size_w = 16'($urandom);
      it.size_h = 16'($urandom);
    end else begin
      // small screen so hit tests land
      it.pos_x  = 16'($signed($urandom_range(700)) - 50);
      it.pos_y  = 16'($signed($urandom_range(500)) - 50);
      it.size_w = 16'($signed($urandom_range(300)) - 10);
      it.size_h = 16'($signed($urandom_range(300)) - 10);
    end
    it.style_bits = 16'($urandom);
    return it;
  endfunction

  task automatic drain_and_settle();
    while (pending_items.size() > 0 || start || busy || expected_results.size() > 0)
      @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [11:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_SCREEN_W: mdl_screen_w = val;
      CFG_WORK_H:   mdl_work_h   = val;
      default:      mdl_modal    = val[4:0];
    endcase
  endtask

  task automatic push_item(logic [3:0] a, logic [4:0] h, logic [15:0] x, logic [15:0] y,
                           logic [15:0] w, logic [15:0] ht, logic [15:0] st);
    item_t it;
    it = '{a, h, x, y, w, ht, st};
    pending_items.push_back(it);
  endtask

  initial begin
    for (int i = 0; i < MAX_WINDOWS; i++) begin
      mdl_marks[i] = '0; mdl_style[i] = '0; mdl_show[i] = '0;
      mdl_frame[i] = '0; mdl_rest[i] = '0; mdl_stack[i] = '0;
    end
    mdl_count = 0; mdl_focus = 0;
    mdl_screen_w = 12'd640; mdl_work_h = 12'd460; mdl_modal = 0;
    mismatches = 0; sender_idle_pct = 0; hold_off = 1'b0;
    cfg_we_i = 1'b0; cfg_idx_i = '0; cfg_data_i = '0;
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty-table cases, then extremes
    push_item(ACT_READ, 5'd0, 0, 0, 0, 0, 0);
    push_item(ACT_FOCUS, 5'd3, 0, 0, 0, 0, 0);
    push_item(ACT_CYCLE, 5'd0, 0, 0, 0, 0, 0);
    push_item(ACT_HIT_TEST, 5'd0, 0, 0, 0, 0, 0);
    push_item(ACT_CREATE, 5'd31, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'hffff);
    push_item(ACT_CREATE, 5'd0, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h0000);
    push_item(ACT_CREATE, 5'd0, 16'd10, 16'd10, 16'h8000, 16'd5, 16'h0178);
    push_item(ACT_HIT_TEST, 5'd0, 16'h7ffe, 16'h7ffe, 0, 0, 0);
    push_item(ACT_HIT_TEST, 5'd0, 16'h8000, 16'h8000, 0, 0, 0);
    push_item(ACT_FOCUS, 5'd1, 0, 0, 0, 0, 0);
    push_item(ACT_FOCUS, 5'd1, 0, 0, 0, 0, 0);
    push_item(ACT_CYCLE, 5'd0, 0, 0, 0, 0, 0);
    push_item(ACT_MAXIMIZE, 5'd2, 0, 0, 0, 0, 0);
    push_item(ACT_READ, 5'd2, 0, 0, 0, 0, 0);
    push_item(ACT_MINIMIZE, 5'd1, 0, 0, 0, 0, 0);
    push_item(ACT_RESTORE, 5'd2, 0, 0, 0, 0, 0);
    push_item(ACT_MOVE, 5'd3, 16'hffff, 16'h1, 0, 0, 0);
    push_item(ACT_RESIZE, 5'd3, 0, 0, 16'd1, 16'hffff, 0);
    push_item(ACT_SET_RECT, 5'd3, 16'd1, 16'd2, 16'd3, 16'd4, 0);
    push_item(ACT_HIDE, 5'd3, 0, 0, 0, 0, 0);
    push_item(ACT_SHOW, 5'd3, 0, 0, 0, 0, 0);
    push_item(4'd14, 5'd1, 0, 0, 0, 0, 0);
    push_item(4'd15, 5'd1, 0, 0, 0, 0, 0);
    push_item(ACT_FOCUS, 5'd0, 0, 0, 0, 0, 0);
    push_item(ACT_DESTROY, 5'd2, 0, 0, 0, 0, 0);
    push_item(ACT_READ, 5'd2, 0, 0, 0, 0, 0);
    drain_and_settle();

    // full table, then create refused
    for (int i = 0; i < 17; i++) push_item(ACT_CREATE, 0, 16'(i*20), 16'(i*10), 64, 48, 0);
    drain_and_settle();

    // random phases, register settings changed while idle
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin write_reg(CFG_SCREEN_W, 12'd1); write_reg(CFG_WORK_H, 12'd4095); end
        1: begin write_reg(CFG_SCREEN_W, 12'd4095); write_reg(CFG_WORK_H, 12'd1); end
        2: write_reg(CFG_MODAL, 12'($urandom_range(MAX_WINDOWS, 1)));
        3: write_reg(CFG_MODAL, 12'd16);
        4: write_reg(CFG_MODAL, 12'd0);
        default: begin
          write_reg(CFG_SCREEN_W, 12'($urandom_range(4095, 1)));
          write_reg(CFG_WORK_H, 12'($urandom_range(4095, 1)));
        end
      endcase
      case (ph % 4)
        0: sender_idle_pct = 0;
        1: sender_idle_pct = 68;
        2: sender_idle_pct = 0;
        default: sender_idle_pct = 19;
      endcase
      for (int n = 0; n < 210; n++) pending_items.push_back(random_item());
      if (ph == 2) begin
        // sender holds off until everything is back
        repeat (100) @(posedge clk_i);
        hold_off = 1'b1;
        while (start || busy || expected_results.size() > 0) @(posedge clk_i);
        hold_off = 1'b0;
      end
      drain_and_settle();
    end

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/wzf_pkg.sv
hw/rtl/wzf_slot_mem.sv
hw/rtl/wzf_zstack_mem.sv
hw/rtl/window_zorder_focus_table.sv
tb/window_zorder_focus_table_tb.sv
